### hw/rtl/tsrd_pkg.sv
package tsrd_pkg;

   // The ring depth is a power of two so that offsets wrap by plain truncation.
   localparam int DEPTH     = 1024;
   localparam int AW        = $clog2(DEPTH);
   localparam int NUM_TAPS  = 4;
   localparam int TIME_BITS = 32;
   localparam int TAP_W     = 2;
   localparam int CNT_W     = 3;
   localparam int CSR_IW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_IW-1:0] CSR_TAP_COUNT = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_DELAY0    = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_DELAY1    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_DELAY2    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DELAY3    = 3'd4;

   localparam logic MODE_ADVANCE = 1'b0;
   localparam logic MODE_REWIND  = 1'b1;

endpackage

### hw/rtl/tsrd_ring_ram.sv
module tsrd_ring_ram
   import tsrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [TIME_BITS-1:0] wdata,
   input  logic [AW-1:0]        raddr,
   output logic [TIME_BITS-1:0] rdata
);

   logic [TIME_BITS-1:0] mem [DEPTH];
   logic [TIME_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/timestamp_ring_delay_tap_tracker.sv
// Timestamp ring with up to four delay taps.
// A request is taken when start is high and busy is low. Mode advance stores
// req_timestamp in the ring and then produces one result per active tap, in
// ascending tap order; mode rewind clears the fill count, returns every tap
// to warm-up and produces no result, staying ready in the next cycle.
// Each result is shown on the rsp_ ports for one cycle with rsp_valid high,
// and rsp_last_tap marks the final result of an advance. The receiver cannot
// stall; results are never held back.
// Steps of an advance: the ring write, then per tap either a single warm-up
// step, or an offset clamp, then a read and a compare per search probe, a
// settle step, and a read of each neighbor plus a rounding step when the
// rounding step is needed; a closing step returns to idle. Each result
// leaves its output register in the cycle after it is decided. The ring RAM
// has a single read port with a registered read, and every probe waits for
// it, so the search length of each tap sets the total.
// Configuration is written through csr_we, csr_index and csr_wdata; the user
// must write it only while the block is idle; the block does not check this.
// Synchronous reset clears the fill count, tap offsets and configuration and
// puts all taps in warm-up; ring contents stay, and no entry is read unwritten.
module timestamp_ring_delay_tap_tracker
   import tsrd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [31:0]          req_timestamp,
   output logic                 rsp_valid,
   output logic [TAP_W-1:0]     rsp_tap_index,
   output logic [AW-1:0]        rsp_tap_offset,
   output logic                 rsp_warming,
   output logic                 rsp_last_tap,
   input  logic                 csr_we,
   input  logic [CSR_IW-1:0]    csr_index,
   input  logic [CSR_DW-1:0]    csr_wdata
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_WRITE = 9'b000000010,
      S_TAP   = 9'b000000100,
      S_RD    = 9'b000001000,
      S_CMP   = 9'b000010000,
      S_POST  = 9'b000100000,
      S_RA    = 9'b001000000,
      S_RB    = 9'b010000000,
      S_RND   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     tap_count_ff;
   logic [31:0]          delay_ff [NUM_TAPS];
   logic [AW-1:0]        offs_ff [NUM_TAPS];
   logic [AW-1:0]        offs_in [NUM_TAPS];
   logic                 warm_ff [NUM_TAPS];
   logic                 warm_in [NUM_TAPS];

   logic [AW-1:0]        wi_ff, wi_in;
   logic                 wrapped_ff, wrapped_in;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     k_ff, k_in;
   logic [AW-1:0]        o_ff, o_in;
   logic                 up_ff, up_in;
   logic                 dn_ff, dn_in;
   logic                 first_ff, first_in;
   logic [TIME_BITS-1:0] a_ff, a_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TAP_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [AW-1:0]        rsp_off_ff, rsp_off_in;
   logic                 rsp_warm_ff, rsp_warm_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_raddr;
   logic [TIME_BITS-1:0] ram_rdata;

   logic [TAP_W-1:0]     kx;
   logic [31:0]          d_cur;
   logic [AW-1:0]        span;
   logic [TIME_BITS:0]   s_sum;
   logic                 c_lt, c_gt;
   logic [TIME_BITS+1:0] rnd_left, rnd_right;
   logic                 emit;
   logic [AW-1:0]        emit_off;
   logic                 emit_warm;
   logic                 u, dd;
   logic [AW-1:0]        on;
   logic                 accept;

   function automatic logic search_on(input logic fu, input logic fd,
                                      input logic [AW-1:0] fo,
                                      input logic [AW-1:0] fspan);
      search_on = (fu != fd) && (fu || (fo != fspan)) && (fd || (fo != '0));
   endfunction

   tsrd_ring_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wi_ff),
      .wdata (t_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign kx     = k_ff[TAP_W-1:0];
   assign d_cur  = delay_ff[kx];
   assign span   = wrapped_ff ? AW'(DEPTH - 1) : (wi_ff - AW'(1));
   assign s_sum  = {1'b0, ram_rdata} + {1'b0, d_cur};
   assign c_lt   = s_sum < {1'b0, t_ff};
   assign c_gt   = s_sum > {1'b0, t_ff};
   assign rnd_left  = {1'b0, t_ff, 1'b0};
   assign rnd_right = {2'b00, a_ff} + {2'b00, ram_rdata} + {1'b0, d_cur, 1'b0};
   assign ram_we = (state_ff == S_WRITE);

   always_comb begin
      ram_raddr = wi_ff - o_ff;
      case (state_ff)
         S_RA: begin
            ram_raddr = (up_ff && dn_ff) ? (wi_ff - o_ff) : (wi_ff - (o_ff + AW'(1)));
         end
         S_RB: begin
            ram_raddr = (up_ff && dn_ff) ? (wi_ff - (o_ff - AW'(1))) : (wi_ff - o_ff);
         end
         default: begin
            ram_raddr = wi_ff - o_ff;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      wi_in      = wi_ff;
      wrapped_in = wrapped_ff;
      t_in       = t_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      o_in       = o_ff;
      up_in      = up_ff;
      dn_in      = dn_ff;
      first_in   = first_ff;
      a_in       = a_ff;
      offs_in    = offs_ff;
      warm_in    = warm_ff;
      emit       = 1'b0;
      emit_off   = o_ff;
      emit_warm  = 1'b0;
      u          = up_ff;
      dd         = dn_ff;
      on         = o_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_REWIND) begin
                  wi_in      = '0;
                  wrapped_in = 1'b0;
                  for (int i = 0; i < NUM_TAPS; i++) begin
                     warm_in[i] = 1'b1;
                  end
               end else begin
                  wi_in = wi_ff + AW'(1);
                  if (wi_in == '0) begin
                     wrapped_in = 1'b1;
                  end
                  t_in     = req_timestamp;
                  n_in     = (tap_count_ff > CNT_W'(NUM_TAPS)) ? CNT_W'(NUM_TAPS)
                                                             : tap_count_ff;
                  k_in     = '0;
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            state_in = S_TAP;
         end
         S_TAP: begin
            if (k_ff >= n_ff) begin
               state_in = S_IDLE;
            end else if (warm_ff[kx]) begin
               emit      = 1'b1;
               emit_off  = wi_ff - AW'(1);
               emit_warm = 1'b1;
               if (t_ff >= d_cur) begin
                  warm_in[kx] = 1'b0;
               end
            end else begin
               o_in     = (offs_ff[kx] > span) ? span : offs_ff[kx];
               first_in = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            u  = first_ff ? c_lt : up_ff;
            dd = first_ff ? !c_lt : dn_ff;
            on = o_ff;
            state_in = S_POST;
            if (search_on(u, dd, o_ff, span)) begin
               if (c_gt) begin
                  dd = 1'b1;
                  on = o_ff + AW'(1);
               end else if (c_lt) begin
                  dd = 1'b0;
                  on = o_ff - AW'(1);
               end
               if ((c_gt || c_lt) && search_on(u, dd, on, span)) begin
                  state_in = S_RD;
               end
            end
            up_in    = u;
            dn_in    = dd;
            o_in     = on;
            first_in = 1'b0;
         end
         S_POST: begin
            dd = dn_ff;
            on = o_ff;
            if (up_ff && !dn_ff && (o_ff == '0)) begin
               on = AW'(1);
               dd = 1'b1;
            end else if (!up_ff && dn_ff && (o_ff == span)) begin
               on = o_ff - AW'(1);
               dd = 1'b0;
            end
            dn_in = dd;
            o_in  = on;
            if (up_ff == dd) begin
               state_in = S_RA;
            end else begin
               emit     = 1'b1;
               emit_off = on;
            end
         end
         S_RA: begin
            state_in = S_RB;
         end
         S_RB: begin
            a_in     = ram_rdata;
            state_in = S_RND;
         end
         S_RND: begin
            emit_off = o_ff;
            if (up_ff && dn_ff && (rnd_left > rnd_right)) begin
               emit_off = o_ff - AW'(1);
            end else if (!up_ff && !dn_ff && (rnd_left < rnd_right)) begin
               emit_off = o_ff + AW'(1);
            end
            emit = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (emit) begin
         offs_in[kx] = emit_off;
         k_in        = k_ff + CNT_W'(1);
         state_in    = S_TAP;
      end
   end

   assign rsp_valid_in = emit;
   assign rsp_idx_in   = kx;
   assign rsp_off_in   = emit_off;
   assign rsp_warm_in  = emit_warm;
   assign rsp_last_in  = (k_ff + CNT_W'(1)) == n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wi_ff        <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tap_count_ff <= '0;
         for (int i = 0; i < NUM_TAPS; i++) begin
            delay_ff[i] <= '0;
            offs_ff[i]  <= '0;
            warm_ff[i]  <= 1'b1;
         end
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         offs_ff      <= offs_in;
         warm_ff      <= warm_in;
         if (csr_we) begin
            case (csr_index)
               CSR_TAP_COUNT: tap_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_DELAY0:    delay_ff[0]  <= csr_wdata;
               CSR_DELAY1:    delay_ff[1]  <= csr_wdata;
               CSR_DELAY2:    delay_ff[2]  <= csr_wdata;
               CSR_DELAY3:    delay_ff[3]  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      o_ff        <= o_in;
      up_ff       <= up_in;
      dn_ff       <= dn_in;
      first_ff    <= first_in;
      a_ff        <= a_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_warm_ff <= rsp_warm_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tap_index  = rsp_idx_ff;
   assign rsp_tap_offset = rsp_off_ff;
   assign rsp_warming    = rsp_warm_ff;
   assign rsp_last_tap   = rsp_last_ff;

endmodule

### hw/rtl/tsrd_checker.sv
module tsrd_checker
   import tsrd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             req_mode,
   input logic             rsp_valid,
   input logic             rsp_last_tap
);

   // A result always comes out of a request that was still in progress.
   a_valid_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in progress");

   // More results follow, so the block must still be working.
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_tap |-> busy)
      else $error("idle before the final result");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_tap |=> !rsp_valid)
      else $error("result right after the final one");

   a_rewind_quick: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_REWIND) |=> !busy && !rsp_valid)
      else $error("rewind request kept the block busy");

endmodule

bind timestamp_ring_delay_tap_tracker tsrd_checker u_tsrd_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_mode     (req_mode),
   .rsp_valid    (rsp_valid),
   .rsp_last_tap (rsp_last_tap)
);
